FILE: design/jsls_pkg.sv
package jsls_pkg;

    localparam int VALUE_BITS = 32;
    localparam int ACC_BITS   = 38;
    localparam int DIV_STEPS  = 49;

    localparam logic [1:0] KIND_MATRIX = 2'd0;
    localparam logic [1:0] KIND_FREE   = 2'd1;
    localparam logic [1:0] KIND_GUESS  = 2'd2;
    localparam logic [1:0] KIND_SOLVE  = 2'd3;

    localparam logic [1:0] STAT_CONVERGED = 2'd0;
    localparam logic [1:0] STAT_NOT_DOM   = 2'd1;
    localparam logic [1:0] STAT_ZERO_DIAG = 2'd2;
    localparam logic [1:0] STAT_LIMIT     = 2'd3;

    localparam logic [1:0] CFG_SIZE   = 2'd0;
    localparam logic [1:0] CFG_TOL    = 2'd1;
    localparam logic [1:0] CFG_METHOD = 2'd2;
    localparam logic [1:0] CFG_LIMIT  = 2'd3;

    typedef logic signed [VALUE_BITS-1:0] t_value;
    typedef logic [VALUE_BITS-1:0]        t_mag;

    typedef struct packed {
        logic start;
        logic neg;
        t_mag num_mag;
        t_mag den_mag;
    } t_div_req;

    function automatic t_mag f_mag(input t_value v);
        return v[VALUE_BITS-1] ? t_mag'(-v) : t_mag'(v);
    endfunction

    function automatic t_value f_from_mag(input logic neg, input logic [63:0] mag);
        logic [63:0] lim;
        lim = 64'd1 << (VALUE_BITS - 1);
        if (mag >= lim) begin
            return neg ? t_value'(lim) : t_value'(lim - 64'd1);
        end
        return neg ? t_value'(-mag) : t_value'(mag);
    endfunction

    function automatic t_value f_sat_acc(input logic signed [ACC_BITS-1:0] a);
        logic signed [ACC_BITS-1:0] hi;
        logic signed [ACC_BITS-1:0] lo;
        hi = (ACC_BITS'(1) <<< (VALUE_BITS - 1)) - ACC_BITS'(1);
        lo = -(ACC_BITS'(1) <<< (VALUE_BITS - 1));
        if (a > hi) begin
            return t_value'(hi);
        end else if (a < lo) begin
            return t_value'(lo);
        end
        return t_value'(a);
    endfunction

endpackage

FILE: design/jsls_div.sv
module jsls_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  jsls_pkg::t_div_req  i_req,
    output logic                o_done,
    output jsls_pkg::t_value    o_quot
);

    logic [jsls_pkg::DIV_STEPS-1:0] r_dvd;
    jsls_pkg::t_mag                 r_rem;
    jsls_pkg::t_mag                 r_den;
    logic                           r_neg;
    logic [5:0]                     r_cnt;
    logic                           r_run;
    logic                           r_done;
    logic [jsls_pkg::VALUE_BITS:0]  w_trial;
    logic                           w_ge;

    assign w_trial = {r_rem, r_dvd[jsls_pkg::DIV_STEPS-1]};
    assign w_ge    = w_trial >= {1'b0, r_den};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_dvd <= jsls_pkg::DIV_STEPS'({i_req.num_mag, 16'd0})
                       + jsls_pkg::DIV_STEPS'(i_req.den_mag >> 1);
                r_rem <= '0;
                r_den <= i_req.den_mag;
                r_neg <= i_req.neg;
                r_cnt <= 6'(jsls_pkg::DIV_STEPS);
                r_run <= 1'b1;
            end else if (r_run) begin
                r_rem <= w_ge ? jsls_pkg::VALUE_BITS'(w_trial - {1'b0, r_den})
                              : w_trial[jsls_pkg::VALUE_BITS-1:0];
                r_dvd <= {r_dvd[jsls_pkg::DIV_STEPS-2:0], w_ge};
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = jsls_pkg::f_from_mag(r_neg, 64'(r_dvd));

endmodule

FILE: design/jsls_mulq.sv
module jsls_mulq (
    input  logic             i_clk,
    input  logic             i_en,
    input  jsls_pkg::t_value i_a,
    input  jsls_pkg::t_value i_b,
    output jsls_pkg::t_value o_prod
);

    logic [63:0] r_mag;
    logic        r_neg;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= 64'(jsls_pkg::f_mag(i_a)) * 64'(jsls_pkg::f_mag(i_b));
            r_neg <= i_a[jsls_pkg::VALUE_BITS-1] != i_b[jsls_pkg::VALUE_BITS-1];
        end
    end

    assign o_prod = jsls_pkg::f_from_mag(r_neg, (r_mag + 64'h8000) >> 16);

endmodule

FILE: design/jacobi_seidel_linear_solver.sv
// Iterative linear solver, Jacobi or Gauss-Seidel, signed Q16.16. Load words (matrix entry,
// free term, start guess) are taken while busy is low and may come back to back. A solve word holds
// busy high through a dominance check that reads each coefficient in turn, then row scaling of each
// off-diagonal entry and free term on the 49-step bit-serial divider, then sweeps on the one shared
// multiplier, then the result words; a failed dominance check gives one status word instead.
// Each result word is shown for exactly one cycle with o_valid; the receiver cannot stall,
// so it must take every word as it appears. o_last_result marks the final word of a solve.
module jacobi_seidel_linear_solver #(
    parameter int MAX_SIZE = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_kind,
    input  logic [3:0]  i_row_index,
    input  logic [3:0]  i_col_index,
    input  logic signed [31:0] i_value,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_idx,
    input  logic [30:0] i_cfg_data,
    output logic        o_valid,
    output logic [3:0]  o_unknown_index,
    output logic signed [31:0] o_unknown_value,
    output logic [15:0] o_sweep_count,
    output logic [1:0]  o_status,
    output logic        o_last_result
);

    localparam int D  = (MAX_SIZE < 16) ? MAX_SIZE : 16;
    localparam int IW = $clog2(D);
    localparam int AW = $clog2(D * D);
    localparam logic [4:0] DN = 5'(D);
    localparam int AB = jsls_pkg::ACC_BITS;
    localparam int VB = jsls_pkg::VALUE_BITS;

    typedef enum logic [3:0] {
        S_IDLE, S_DOM, S_SC_DIAG, S_SC_TERM, S_SC_WAIT,
        S_SW_START, S_SW_TERM, S_SW_ROW, S_SW_CHECK, S_OUT
    } t_state;

    t_state r_state;
    logic [4:0]  r_size;
    logic [30:0] r_tol;
    logic        r_method;
    logic [15:0] r_limit;
    logic [4:0]  r_i, r_j;
    logic [1:0]  r_ph;
    logic [35:0] r_rest;
    jsls_pkg::t_mag r_diag, r_den;
    logic        r_zero, r_den_neg, r_ctsel;
    logic signed [AB-1:0] r_acc;
    logic [32:0] r_chg;
    logic [15:0] r_sweep;
    logic [1:0]  r_status;
    jsls_pkg::t_div_req r_dreq;
    logic        r_valid, r_last;
    logic [3:0]  r_oidx;
    jsls_pkg::t_value r_oval;
    logic [15:0] r_osweep;
    logic [1:0]  r_ostat;

    jsls_pkg::t_value r_coef_mem [D*D];
    jsls_pkg::t_value r_mrow_mem [D*D];
    jsls_pkg::t_value r_coef_q, r_mrow_q;
    jsls_pkg::t_value r_free [D];
    jsls_pkg::t_value r_cur  [D];
    jsls_pkg::t_value r_prev [D];
    jsls_pkg::t_value r_ct   [D];

    logic [4:0]  w_n;
    logic [15:0] w_lim;
    logic        w_load;
    logic [AW-1:0] w_addr, w_ld_addr;
    logic        w_div_done, w_mul_en, w_wr_m, w_wr_ct;
    jsls_pkg::t_value w_quot, w_prod, w_cur_rd, w_prev_rd, w_src, w_new, w_ct_rd;
    jsls_pkg::t_mag w_m, w_diag_new;
    logic [35:0] w_rest_new;
    logic        w_zero_new;
    logic signed [32:0] w_dif;
    logic [32:0] w_dmag;
    logic [IW-1:0] w_cur_i, w_prev_i, w_ct_i;

    function automatic logic [AW-1:0] f_addr(input logic [4:0] r, input logic [4:0] c);
        return AW'(int'(r) * D + int'(c));
    endfunction

    assign w_n    = (r_size == 5'd0) ? 5'd1 : ((r_size > DN) ? DN : r_size);
    assign w_lim  = (r_limit == 16'd0) ? 16'd1 : r_limit;
    assign w_load = start && !busy;
    assign busy   = r_state != S_IDLE;

    assign w_addr    = (r_state == S_SC_DIAG) ? f_addr(r_i, r_i) : f_addr(r_i, r_j);
    assign w_ld_addr = f_addr({1'b0, i_row_index}, {1'b0, i_col_index});

    assign w_cur_i  = (r_state == S_OUT) ? r_i[IW-1:0] : r_j[IW-1:0];
    assign w_prev_i = (r_state == S_SW_ROW) ? r_i[IW-1:0] : r_j[IW-1:0];
    assign w_ct_i   = (r_state == S_SW_START) ? '0 : IW'(r_i + 5'd1);
    assign w_cur_rd  = r_cur[w_cur_i];
    assign w_prev_rd = r_prev[w_prev_i];
    assign w_ct_rd   = r_ct[w_ct_i];
    assign w_src     = r_method ? w_cur_rd : w_prev_rd;

    assign w_m        = jsls_pkg::f_mag(r_coef_q);
    assign w_rest_new = (r_j == r_i) ? r_rest : r_rest + 36'(w_m);
    assign w_diag_new = (r_j == r_i) ? w_m : r_diag;
    assign w_zero_new = r_zero || (r_j == r_i && w_m == '0);

    assign w_new  = jsls_pkg::f_sat_acc(r_acc);
    assign w_dif  = {w_new[VB-1], w_new} - {w_prev_rd[VB-1], w_prev_rd};
    assign w_dmag = w_dif[32] ? 33'(-w_dif) : 33'(w_dif);

    assign w_mul_en = (r_state == S_SW_TERM) && (r_ph == 2'd1);
    assign w_wr_m   = (r_state == S_SC_WAIT) && w_div_done && !r_ctsel;
    assign w_wr_ct  = (r_state == S_SC_WAIT) && w_div_done && r_ctsel;

    jsls_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (r_dreq),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    jsls_mulq u_mul (
        .i_clk  (i_clk),
        .i_en   (w_mul_en),
        .i_a    (r_mrow_q),
        .i_b    (w_src),
        .o_prod (w_prod)
    );

    always_ff @(posedge i_clk) begin
        if (w_load && i_kind == jsls_pkg::KIND_MATRIX
                && {1'b0, i_row_index} < DN && {1'b0, i_col_index} < DN) begin
            r_coef_mem[w_ld_addr] <= i_value;
        end
        r_coef_q <= r_coef_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_wr_m) begin
            r_mrow_mem[w_addr] <= w_quot;
        end
        r_mrow_q <= r_mrow_mem[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_kind == jsls_pkg::KIND_FREE && {1'b0, i_row_index} < DN) begin
            r_free[i_row_index[IW-1:0]] <= i_value;
        end
        if (w_wr_ct) begin
            r_ct[r_i[IW-1:0]] <= w_quot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load && i_kind == jsls_pkg::KIND_GUESS && {1'b0, i_row_index} < DN) begin
            r_cur[i_row_index[IW-1:0]] <= i_value;
        end else if (r_state == S_SW_ROW) begin
            r_cur[r_i[IW-1:0]] <= w_new;
        end
        if (r_state == S_SW_START) begin
            r_prev <= r_cur;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_size   <= 5'd1;
            r_tol    <= 31'd66;
            r_method <= 1'b0;
            r_limit  <= 16'd1000;
            r_sweep  <= '0;
            r_valid  <= 1'b0;
            r_dreq   <= '0;
            r_ph     <= '0;
            r_i      <= '0;
            r_j      <= '0;
        end else begin
            r_valid      <= 1'b0;
            r_dreq.start <= 1'b0;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    jsls_pkg::CFG_SIZE:   r_size   <= i_cfg_data[4:0];
                    jsls_pkg::CFG_TOL:    r_tol    <= i_cfg_data;
                    jsls_pkg::CFG_METHOD: r_method <= i_cfg_data[0];
                    jsls_pkg::CFG_LIMIT:  r_limit  <= i_cfg_data[15:0];
                endcase
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_load && i_kind == jsls_pkg::KIND_SOLVE) begin
                        r_state <= S_DOM;
                        r_i     <= '0;
                        r_j     <= '0;
                        r_ph    <= '0;
                        r_rest  <= '0;
                        r_zero  <= 1'b0;
                    end
                end
                S_DOM: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph   <= 2'd0;
                        r_rest <= w_rest_new;
                        r_diag <= w_diag_new;
                        r_zero <= w_zero_new;
                        r_j    <= r_j + 5'd1;
                        if (r_j == w_n - 5'd1) begin
                            r_rest <= '0;
                            r_j    <= '0;
                            r_i    <= r_i + 5'd1;
                            if (36'(w_diag_new) < w_rest_new) begin
                                r_state  <= S_IDLE;
                                r_sweep  <= '0;
                                r_valid  <= 1'b1;
                                r_oidx   <= '0;
                                r_oval   <= '0;
                                r_osweep <= '0;
                                r_ostat  <= jsls_pkg::STAT_NOT_DOM;
                                r_last   <= 1'b1;
                            end else if (r_i == w_n - 5'd1) begin
                                if (w_zero_new) begin
                                    r_state  <= S_IDLE;
                                    r_sweep  <= '0;
                                    r_valid  <= 1'b1;
                                    r_oidx   <= '0;
                                    r_oval   <= '0;
                                    r_osweep <= '0;
                                    r_ostat  <= jsls_pkg::STAT_ZERO_DIAG;
                                    r_last   <= 1'b1;
                                end else begin
                                    r_state <= S_SC_DIAG;
                                    r_i     <= '0;
                                end
                            end
                        end
                    end
                end
                S_SC_DIAG: begin
                    if (r_ph == 2'd0) begin
                        r_ph <= 2'd1;
                    end else begin
                        r_ph      <= 2'd0;
                        r_den     <= w_m;
                        r_den_neg <= r_coef_q[VB-1];
                        r_j       <= '0;
                        r_state   <= S_SC_TERM;
                    end
                end
                S_SC_TERM: begin
                    if (r_ph == 2'd0) begin
                        if (r_j == w_n) begin
                            r_dreq.start   <= 1'b1;
                            r_dreq.num_mag <= jsls_pkg::f_mag(r_free[r_i[IW-1:0]]);
                            r_dreq.den_mag <= r_den;
                            r_dreq.neg     <= r_free[r_i[IW-1:0]][VB-1] ^ r_den_neg;
                            r_ctsel        <= 1'b1;
                            r_state        <= S_SC_WAIT;
                        end else if (r_j == r_i) begin
                            r_j <= r_j + 5'd1;
                        end else begin
                            r_ph <= 2'd1;
                        end
                    end else begin
                        r_ph           <= 2'd0;
                        r_dreq.start   <= 1'b1;
                        r_dreq.num_mag <= w_m;
                        r_dreq.den_mag <= r_den;
                        r_dreq.neg     <= (r_coef_q != '0 && !r_coef_q[VB-1]) ^ r_den_neg;
                        r_ctsel        <= 1'b0;
                        r_state        <= S_SC_WAIT;
                    end
                end
                S_SC_WAIT: begin
                    if (w_div_done) begin
                        if (r_ctsel) begin
                            r_i <= r_i + 5'd1;
                            r_j <= '0;
                            r_state <= (r_i == w_n - 5'd1) ? S_SW_START : S_SC_DIAG;
                            r_sweep <= '0;
                        end else begin
                            r_j     <= r_j + 5'd1;
                            r_state <= S_SC_TERM;
                        end
                    end
                end
                S_SW_START: begin
                    r_sweep <= r_sweep + 16'd1;
                    r_chg   <= '0;
                    r_i     <= '0;
                    r_j     <= '0;
                    r_ph    <= '0;
                    r_acc   <= AB'(w_ct_rd);
                    r_state <= S_SW_TERM;
                end
                S_SW_TERM: begin
                    unique case (r_ph)
                        2'd0: begin
                            if (r_j == w_n) begin
                                r_state <= S_SW_ROW;
                            end else if (r_j == r_i) begin
                                r_j <= r_j + 5'd1;
                            end else begin
                                r_ph <= 2'd1;
                            end
                        end
                        2'd1: r_ph <= 2'd2;
                        default: begin
                            r_acc <= r_acc + AB'(w_prod);
                            r_j   <= r_j + 5'd1;
                            r_ph  <= 2'd0;
                        end
                    endcase
                end
                S_SW_ROW: begin
                    if (w_dmag > r_chg) begin
                        r_chg <= w_dmag;
                    end
                    if (r_i == w_n - 5'd1) begin
                        r_state <= S_SW_CHECK;
                    end else begin
                        r_i     <= r_i + 5'd1;
                        r_j     <= '0;
                        r_acc   <= AB'(w_ct_rd);
                        r_state <= S_SW_TERM;
                    end
                end
                S_SW_CHECK: begin
                    r_i <= '0;
                    if (r_chg <= 33'(r_tol)) begin
                        r_status <= jsls_pkg::STAT_CONVERGED;
                        r_state  <= S_OUT;
                    end else if (r_sweep >= w_lim) begin
                        r_status <= jsls_pkg::STAT_LIMIT;
                        r_state  <= S_OUT;
                    end else begin
                        r_state <= S_SW_START;
                    end
                end
                S_OUT: begin
                    r_valid  <= 1'b1;
                    r_oidx   <= r_i[3:0];
                    r_oval   <= w_cur_rd;
                    r_osweep <= r_sweep;
                    r_ostat  <= r_status;
                    r_last   <= r_i == w_n - 5'd1;
                    r_i      <= r_i + 5'd1;
                    if (r_i == w_n - 5'd1) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_valid;
    assign o_unknown_index = r_oidx;
    assign o_unknown_value = r_oval;
    assign o_sweep_count   = r_osweep;
    assign o_status        = r_ostat;
    assign o_last_result   = r_last;

`ifndef SYNTHESIS
    a_last_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_result |=> !o_valid)
        else $error("word right after last word");
    a_run_on: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_last_result |=> o_valid)
        else $error("gap inside a run of results");
    a_fail_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_status == jsls_pkg::STAT_NOT_DOM || o_status == jsls_pkg::STAT_ZERO_DIAG)
        |-> o_last_result && o_sweep_count == 16'd0 && o_unknown_value == '0)
        else $error("failed check word malformed");
    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> r_state == S_SC_WAIT)
        else $error("divider finished outside scaling");
`endif

endmodule
